/* sv/fnta_pkg.sv */
`default_nettype none
package fnta_pkg;

   // input format codes
   localparam logic [1:0] CMD_UDEC = 2'd0;
   localparam logic [1:0] CMD_SDEC = 2'd1;
   localparam logic [1:0] CMD_HEX  = 2'd2;
   localparam logic [1:0] CMD_BIN  = 2'd3;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // ceil(2^35 / 10): (v * RECIP10) >> 35 == v / 10 for every 32-bit v
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DIGIT = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SIGN  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_LOAD  = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIGIT = 3'd3,
      OP_SIGN  = 3'd4,
      OP_EMIT  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS    = 3'd0,
      COND_START     = 3'd1,
      COND_LEN_ZERO  = 3'd2,
      COND_DIG_DONE  = 3'd3,
      COND_EMIT_LAST = 3'd4
   } cond_type;

   typedef struct packed {
      op_type                 op;
      cond_type               cond;
      logic [STEP_W-1:0]      jump_true;
      logic [STEP_W-1:0]      jump_false;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic len_zero;
      logic dig_done;
      logic emit_last;
   } flags_type;

   function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = CHAR_ZERO + {3'b000, digit};
      end else begin
         code = CHAR_UPPER_A + {3'b000, digit} - 7'd10;
      end
      return code;
   endfunction

endpackage
`default_nettype wire

/* sv/fnta_sequencer.sv */
`default_nettype none
module fnta_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire fnta_pkg::flags_type  flags,
   output fnta_pkg::ctrl_type        ctrl,
   output logic                      busy
);

   logic [fnta_pkg::STEP_W-1:0] step_ff;
   logic [fnta_pkg::STEP_W-1:0] step_in;
   fnta_pkg::ucode_word_type    word;
   logic                        cond_true;

   function automatic fnta_pkg::ucode_word_type ucode_rom(
      input logic [fnta_pkg::STEP_W-1:0] step
   );
      fnta_pkg::ucode_word_type w;
      unique case (step)
         fnta_pkg::STEP_WAIT:
            w = '{fnta_pkg::OP_LOAD, fnta_pkg::COND_START,
                  fnta_pkg::STEP_CHECK, fnta_pkg::STEP_WAIT};
         fnta_pkg::STEP_CHECK:
            w = '{fnta_pkg::OP_NOP, fnta_pkg::COND_LEN_ZERO,
                  fnta_pkg::STEP_SIGN, fnta_pkg::STEP_MUL};
         fnta_pkg::STEP_MUL:
            w = '{fnta_pkg::OP_MUL, fnta_pkg::COND_ALWAYS,
                  fnta_pkg::STEP_DIGIT, fnta_pkg::STEP_DIGIT};
         fnta_pkg::STEP_DIGIT:
            w = '{fnta_pkg::OP_DIGIT, fnta_pkg::COND_DIG_DONE,
                  fnta_pkg::STEP_SIGN, fnta_pkg::STEP_MUL};
         fnta_pkg::STEP_SIGN:
            w = '{fnta_pkg::OP_SIGN, fnta_pkg::COND_LEN_ZERO,
                  fnta_pkg::STEP_WAIT, fnta_pkg::STEP_EMIT};
         fnta_pkg::STEP_EMIT:
            w = '{fnta_pkg::OP_EMIT, fnta_pkg::COND_EMIT_LAST,
                  fnta_pkg::STEP_WAIT, fnta_pkg::STEP_EMIT};
         default:
            w = '{fnta_pkg::OP_NOP, fnta_pkg::COND_ALWAYS,
                  fnta_pkg::STEP_WAIT, fnta_pkg::STEP_WAIT};
      endcase
      return w;
   endfunction

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         fnta_pkg::COND_ALWAYS:    cond_true = 1'b1;
         fnta_pkg::COND_START:     cond_true = start;
         fnta_pkg::COND_LEN_ZERO:  cond_true = flags.len_zero;
         fnta_pkg::COND_DIG_DONE:  cond_true = flags.dig_done;
         fnta_pkg::COND_EMIT_LAST: cond_true = flags.emit_last;
         default:                  cond_true = 1'b1;
      endcase
   end

   assign step_in = cond_true ? word.jump_true : word.jump_false;
   assign ctrl.op = word.op;
   assign busy    = (step_ff != fnta_pkg::STEP_WAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= fnta_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

/* sv/fnta_datapath.sv */
`default_nettype none
module fnta_datapath #(
   parameter int MAX_DIGITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fnta_pkg::ctrl_type   ctrl,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [31:0]          req_number,
   input  wire logic [4:0]           req_digit_count,
   input  wire logic [2:0]           req_text_line,
   input  wire logic [4:0]           req_start_column,
   output fnta_pkg::flags_type       flags,
   output logic                      rsp_valid,
   output logic [6:0]                rsp_char_code,
   output logic [2:0]                rsp_out_line,
   output logic [5:0]                rsp_out_column,
   output logic                      rsp_last
);

   localparam int LEN_W   = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W   = $clog2(MAX_DIGITS);
   localparam int DEC_CAP = (MAX_DIGITS < 10) ? MAX_DIGITS : 10;
   localparam int HEX_CAP = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
   localparam logic [5:0] DEC_CAP6 = 6'(DEC_CAP);
   localparam logic [5:0] HEX_CAP6 = 6'(HEX_CAP);
   localparam logic [5:0] BIN_CAP6 = 6'(MAX_DIGITS);

   logic [1:0]       mode_ff;
   logic             neg_ff;
   logic [31:0]      value_ff;
   logic [28:0]      quot_ff;
   logic [LEN_W-1:0] len_ff;
   logic [2:0]       line_ff;
   logic [5:0]       col_ff;
   logic [IDX_W-1:0] dig_idx_ff;
   logic [IDX_W-1:0] emit_idx_ff;
   logic [3:0]       digits_ff [MAX_DIGITS];

   logic [5:0]       cap6;
   logic [5:0]       want6;
   logic [5:0]       len6;
   logic [5:0]       len6_m1;
   logic             neg_in;
   logic [63:0]      prod;
   logic [3:0]       ten_q_lo;
   logic [3:0]       digit;
   logic [31:0]      value_next;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [6:0]       rsp_char_ff;
   logic [6:0]       rsp_char_in;
   logic [2:0]       rsp_line_ff;
   logic [5:0]       rsp_col_ff;
   logic             rsp_last_ff;
   logic             rsp_last_in;

   // length saturation against the format's maximum
   always_comb begin
      unique case (req_cmd)
         fnta_pkg::CMD_UDEC, fnta_pkg::CMD_SDEC: cap6 = DEC_CAP6;
         fnta_pkg::CMD_HEX:                      cap6 = HEX_CAP6;
         default:                                cap6 = BIN_CAP6;
      endcase
   end

   assign want6   = {1'b0, req_digit_count};
   assign len6    = (want6 > cap6) ? cap6 : want6;
   assign len6_m1 = len6 - 6'd1;
   assign neg_in  = (req_cmd == fnta_pkg::CMD_SDEC) && req_number[31];

   assign prod = 64'(value_ff) * 64'(fnta_pkg::RECIP10);

   // remainder is below ten, so the low nibble of value - 10q is enough
   assign ten_q_lo = {quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0};

   always_comb begin
      unique case (mode_ff)
         fnta_pkg::CMD_UDEC, fnta_pkg::CMD_SDEC: begin
            digit      = value_ff[3:0] - ten_q_lo;
            value_next = {3'b000, quot_ff};
         end
         fnta_pkg::CMD_HEX: begin
            digit      = value_ff[3:0];
            value_next = {4'b0000, value_ff[31:4]};
         end
         default: begin
            digit      = {3'b000, value_ff[0]};
            value_next = {1'b0, value_ff[31:1]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         fnta_pkg::OP_LOAD: begin
            mode_ff     <= req_cmd;
            neg_ff      <= neg_in;
            value_ff    <= neg_in ? (32'd0 - req_number) : req_number;
            len_ff      <= len6[LEN_W-1:0];
            line_ff     <= req_text_line;
            col_ff      <= {1'b0, req_start_column};
            dig_idx_ff  <= '0;
            emit_idx_ff <= len6_m1[IDX_W-1:0];
         end
         fnta_pkg::OP_MUL: begin
            quot_ff <= prod[63:35];
         end
         fnta_pkg::OP_DIGIT: begin
            digits_ff[dig_idx_ff] <= digit;
            value_ff              <= value_next;
            dig_idx_ff            <= dig_idx_ff + 1'b1;
         end
         fnta_pkg::OP_SIGN: begin
            // digits start one column after the sign
            if (mode_ff == fnta_pkg::CMD_SDEC) begin
               col_ff <= col_ff + 6'd1;
            end
         end
         fnta_pkg::OP_EMIT: begin
            emit_idx_ff <= emit_idx_ff - 1'b1;
            col_ff      <= col_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   assign flags.len_zero  = (len_ff == '0);
   assign flags.dig_done  = ((LEN_W'(dig_idx_ff) + 1'b1) == len_ff);
   assign flags.emit_last = (emit_idx_ff == '0);

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_char_in  = fnta_pkg::digit_to_ascii(digits_ff[emit_idx_ff]);
      rsp_last_in  = (emit_idx_ff == '0);
      if (ctrl.op == fnta_pkg::OP_SIGN) begin
         rsp_valid_in = (mode_ff == fnta_pkg::CMD_SDEC);
         rsp_char_in  = neg_ff ? fnta_pkg::CHAR_MINUS : fnta_pkg::CHAR_PLUS;
         rsp_last_in  = (len_ff == '0);
      end else if (ctrl.op == fnta_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_line_ff <= line_ff;
      rsp_col_ff  <= col_ff;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_char_ff;
   assign rsp_out_line   = rsp_line_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire

/* sv/fixed_length_number_to_ascii.sv */
// An item keeps busy high from its check step through its sign or last emit step;
// the next item can start once busy has fallen.
// Each digit takes a reciprocal multiply step and a store step, then one cycle per character.
// Characters leave one per cycle on rsp_valid, in the cycle after their emit step; the
// receiver cannot stall. Synchronous reset returns the sequencer to wait and clears the strobe.
`default_nettype none
module fixed_length_number_to_ascii #(
   parameter int MAX_DIGITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_number,
   input  wire logic [4:0]  req_digit_count,
   input  wire logic [2:0]  req_text_line,
   input  wire logic [4:0]  req_start_column,
   output logic             rsp_valid,
   output logic [6:0]       rsp_char_code,
   output logic [2:0]       rsp_out_line,
   output logic [5:0]       rsp_out_column,
   output logic             rsp_last
);

   fnta_pkg::ctrl_type  ctrl;
   fnta_pkg::flags_type flags;

   fnta_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   fnta_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_cmd          (req_cmd),
      .req_number       (req_number),
      .req_digit_count  (req_digit_count),
      .req_text_line    (req_text_line),
      .req_start_column (req_start_column),
      .flags            (flags),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_out_line     (rsp_out_line),
      .rsp_out_column   (rsp_out_column),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire
